@@ sv/ple_pkg.sv @@
`timescale 1ns / 1ps

package ple_pkg;

  // Window and channel geometry
  localparam int WINDOW_LEN = 3;
  localparam int NUM_CH     = 5;
  localparam int SMP_W      = 32;
  localparam int HOR_W      = 6;
  localparam logic [HOR_W-1:0] HOR_RST = HOR_W'(6);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);

  // Position weight d = 2i - (N-1), signed
  localparam int D_W = $clog2(WINDOW_LEN) + 1;

  // Accumulators: T = sum(y), S = sum(d * y)
  localparam int T_W = SMP_W + $clog2(WINDOW_LEN);
  localparam int S_W = SMP_W + $clog2(WINDOW_LEN * WINDOW_LEN);

  // num = (N^2-1) * T + 3 * (2h + N-1) * S
  localparam int CT    = WINDOW_LEN * WINDOW_LEN - 1;
  localparam int CT_W  = $clog2(CT + 1) + 1;
  localparam int K_OFS = 3 * (WINDOW_LEN - 1);
  localparam int K_MAX = 6 * (2 ** HOR_W - 1) + K_OFS;
  localparam int K_W   = $clog2(K_MAX + 1) + 1;
  localparam int PT_W  = T_W + CT_W;
  localparam int PS_W  = S_W + K_W;
  localparam int NUM_W = PS_W + 1;
  localparam int DVD_W = NUM_W + 1;

  localparam logic signed [CT_W-1:0] CT_C = CT_W'(CT);

  // Rounded division: q = floor((2|num| + DEN) / (2 DEN))
  localparam int DEN   = WINDOW_LEN * CT;
  localparam int DEN2  = 2 * DEN;
  localparam int REM_W = $clog2(DEN2);

  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = SMP_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef logic [NUM_CH-1:0][SMP_W-1:0] row_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } ple_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ple_div_ctl_t;

endpackage

@@ sv/pose_linear_extrapolator.sv @@
`timescale 1ns / 1ps

// Pose linear extrapolator. Each input item is one head-pose sample (eye x, y,
// z, yaw, pitch; signed Q16.16). The last WINDOW_LEN samples sit in a small
// synchronous window memory, one row per sample holding all five channels.
// Items that arrive before the window is full are stored and give no result;
// after that every item gives one result item: for each channel the
// least-squares line over window positions 0 (oldest) to N-1 (newest),
// evaluated horizon samples beyond the newest, rounded to nearest (ties away
// from zero) and saturated to 32 bits. An item that fills or follows a full
// window occupies the block for an accept, memory reads through the single
// read port with sums accumulated behind them, one multiply, one add, one
// divider load, and the five rounded-division lanes at four quotient bits a
// cycle, then a transfer into the output register, which waits while that
// register still holds a result the sink has not taken. The output register
// holds a finished result while the next item is taken in. horizon is written
// through cfg_wr_en / cfg_wr_data and must only change while the block is
// idle.
module pose_linear_extrapolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ple_pkg::HOR_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ple_pkg::SMP_W-1:0]  in_eye_x,
  input  logic signed [ple_pkg::SMP_W-1:0]  in_eye_y,
  input  logic signed [ple_pkg::SMP_W-1:0]  in_eye_z,
  input  logic signed [ple_pkg::SMP_W-1:0]  in_yaw_angle,
  input  logic signed [ple_pkg::SMP_W-1:0]  in_pitch_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ple_pkg::SMP_W-1:0]  out_pred_eye_x,
  output logic signed [ple_pkg::SMP_W-1:0]  out_pred_eye_y,
  output logic signed [ple_pkg::SMP_W-1:0]  out_pred_eye_z,
  output logic signed [ple_pkg::SMP_W-1:0]  out_pred_yaw,
  output logic signed [ple_pkg::SMP_W-1:0]  out_pred_pitch
);
  import ple_pkg::*;

  // Control state
  ple_state_t        state_r, state_nxt;
  logic [HOR_W-1:0]  horizon_r;
  logic [CNT_W-1:0]  fill_count_r;
  slot_t             write_slot_r;
  slot_t             rd_ptr_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              out_valid_r;

  // Datapath registers, one lane per channel
  logic signed [D_W-1:0]   d_r;
  logic signed [T_W-1:0]   t_r   [NUM_CH];
  logic signed [S_W-1:0]   s_r   [NUM_CH];
  logic signed [PT_W-1:0]  pt_r  [NUM_CH];
  logic signed [PS_W-1:0]  ps_r  [NUM_CH];
  logic signed [NUM_W-1:0] num_r [NUM_CH];
  logic [SMP_W-1:0]        res_r [NUM_CH];

  // Wires
  logic         in_acc;
  logic         out_free;
  logic         fill_done;
  slot_t        slot_inc;
  row_t         wr_row;
  row_t         rd_row;
  logic         rd_en;
  ple_div_ctl_t div_ctl;
  logic signed [K_W-1:0] k_s;
  logic [DVD_W-1:0] dvd   [NUM_CH];
  logic             neg   [NUM_CH];
  logic [SMP_W-1:0] lane_res [NUM_CH];

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign slot_inc  = (write_slot_r == slot_t'(WINDOW_LEN - 1)) ? '0 : write_slot_r + 1'b1;
  // The window is full once this item is counted
  assign fill_done = (fill_count_r >= CNT_W'(WINDOW_LEN - 1));
  assign wr_row    = {in_pitch_angle, in_yaw_angle, in_eye_z, in_eye_y, in_eye_x};
  assign rd_en     = (state_r == ST_READ) && (rd_cnt_r < CNT_W'(WINDOW_LEN));

  // Slope coefficient 3 * (2h + N-1), built from shifts
  assign k_s = $signed(K_W'({horizon_r, 2'b00}) + K_W'({horizon_r, 1'b0}) + K_W'(K_OFS));

  ple_window_mem u_mem (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (write_slot_r),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_row)
  );

  // Next state and control strobes
  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    div_ctl.load = 1'b0;
    div_ctl.step = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && fill_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_r == CNT_W'(WINDOW_LEN)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        div_ctl.load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_CYC - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, window bookkeeping and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r    <= HOR_RST;
      fill_count_r <= '0;
      write_slot_r <= '0;
      rd_ptr_r     <= '0;
      rd_cnt_r     <= '0;
      div_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        horizon_r <= cfg_wr_data;
      end
      if (in_acc) begin
        // Advance the write slot; the oldest sample now sits at the new slot
        write_slot_r <= slot_inc;
        rd_ptr_r     <= slot_inc;
        rd_cnt_r     <= '0;
        if (fill_count_r < CNT_W'(WINDOW_LEN)) begin
          fill_count_r <= fill_count_r + 1'b1;
        end
      end
      if (state_r == ST_READ) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
        if (rd_en) begin
          rd_ptr_r <= (rd_ptr_r == slot_t'(WINDOW_LEN - 1)) ? '0 : rd_ptr_r + 1'b1;
        end
      end
      if (state_r == ST_LOAD) begin
        div_cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  // Accumulate, multiply, add; read data is registered and arrives the cycle after its read address
  always_ff @(posedge clk) begin
    logic signed [SMP_W+D_W-1:0] prod;
    prod = '0;
    if (in_acc) begin
      d_r <= -$signed(D_W'(WINDOW_LEN - 1));
      for (int c = 0; c < NUM_CH; c++) begin
        t_r[c] <= '0;
        s_r[c] <= '0;
      end
    end
    if ((state_r == ST_READ) && (rd_cnt_r != '0)) begin
      d_r <= d_r + D_W'(2);
      for (int c = 0; c < NUM_CH; c++) begin
        prod   = d_r * $signed(rd_row[c]);
        t_r[c] <= t_r[c] + T_W'($signed(rd_row[c]));
        s_r[c] <= s_r[c] + S_W'(prod);
      end
    end
    if (state_r == ST_MUL) begin
      for (int c = 0; c < NUM_CH; c++) begin
        pt_r[c] <= t_r[c] * CT_C;
        ps_r[c] <= s_r[c] * k_s;
      end
    end
    if (state_r == ST_SUM) begin
      for (int c = 0; c < NUM_CH; c++) begin
        num_r[c] <= NUM_W'(pt_r[c]) + NUM_W'(ps_r[c]);
      end
    end
  end

  // Dividend 2|num| + DEN in one add: for negative num, 2|num| = 2*~num + 2
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      neg[c] = num_r[c][NUM_W-1];
      if (neg[c]) begin
        dvd[c] = {~num_r[c], 1'b0} + DVD_W'(DEN + 2);
      end else begin
        dvd[c] = {num_r[c], 1'b0} + DVD_W'(DEN);
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    ple_div_lane u_lane (
      .clk (clk),
      .ctl (div_ctl),
      .dvd (dvd[c]),
      .neg (neg[c]),
      .res (lane_res[c])
    );
  end

  // Output register: hold a finished item until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_r[c] <= lane_res[c];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pred_eye_x = $signed(res_r[0]);
  assign out_pred_eye_y = $signed(res_r[1]);
  assign out_pred_eye_z = $signed(res_r[2]);
  assign out_pred_yaw   = $signed(res_r[3]);
  assign out_pred_pitch = $signed(res_r[4]);

endmodule

@@ sv/ple_window_mem.sv @@
`timescale 1ns / 1ps

module ple_window_mem (
  input  logic          clk,
  input  logic          wr_en,
  input  ple_pkg::slot_t wr_addr,
  input  ple_pkg::row_t  wr_data,
  input  logic          rd_en,
  input  ple_pkg::slot_t rd_addr,
  output ple_pkg::row_t  rd_data
);
  import ple_pkg::*;

  row_t mem [WINDOW_LEN];
  row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/ple_div_lane.sv @@
`timescale 1ns / 1ps

module ple_div_lane (
  input  logic                          clk,
  input  ple_pkg::ple_div_ctl_t         ctl,
  input  logic [ple_pkg::DVD_W-1:0]     dvd,
  input  logic                          neg,
  output logic [ple_pkg::SMP_W-1:0]     res
);
  import ple_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SMP_W-1:0] quo_r, quo_nxt;
  logic             neg_r;
  logic             ovf_r;

  // Several restoring steps per cycle on the narrow remainder
  always_comb begin
    logic [REM_W:0]   rem2;
    logic [REM_W-1:0] rem_v;
    logic [SMP_W-1:0] quo_v;
    rem_v = rem_r;
    quo_v = quo_r;
    rem2  = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      rem2 = {rem_v, quo_v[SMP_W-1]};
      if (rem2 >= (REM_W+1)'(DEN2)) begin
        rem2  = rem2 - (REM_W+1)'(DEN2);
        quo_v = {quo_v[SMP_W-2:0], 1'b1};
      end else begin
        quo_v = {quo_v[SMP_W-2:0], 1'b0};
      end
      rem_v = rem2[REM_W-1:0];
    end
    rem_nxt = rem_v;
    quo_nxt = quo_v;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= dvd[SMP_W +: REM_W];
      quo_r <= dvd[SMP_W-1:0];
      neg_r <= neg;
      ovf_r <= (dvd[DVD_W-1:SMP_W] >= (DVD_W-SMP_W)'(DEN2));
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Apply sign and saturate to 32 bits
  always_comb begin
    if (ovf_r) begin
      res = neg_r ? SMP_MIN : SMP_MAX;
    end else if (!neg_r) begin
      res = quo_r[SMP_W-1] ? SMP_MAX : quo_r;
    end else if (quo_r[SMP_W-1] && (|quo_r[SMP_W-2:0])) begin
      res = SMP_MIN;
    end else begin
      res = -quo_r;
    end
  end

endmodule

@@ bench/pose_linear_extrapolator_tb.sv @@
`timescale 1ns / 1ps

// Drive pose samples into the extrapolator and check every prediction it
// returns against a software least-squares predictor kept in step with the
// block. A short directed table comes first: zeros, full-scale constants and
// ramps that must saturate, rounding ties and the horizon extremes. Random
// phases follow, each at its own horizon, with mostly smooth trajectories and
// some raw noise and corner values. Both sides idle at random; the receiver
// once or twice holds off long enough to back the block up to its input.
module pose_linear_extrapolator_tb;
  import ple_pkg::*;

  localparam int WIN        = WINDOW_LEN;
  localparam int SETTLE     = WINDOW_LEN + 20;  // cycles for a busy block to go idle
  localparam int LIMIT      = 400000;           // watchdog, in clock cycles
  localparam int PHASE_LEN  = 160;              // random items per horizon setting
  localparam int LONG_HOLD  = 400;              // receiver hold-off, in cycles

  typedef enum int {CH_X = 0, CH_Y = 1, CH_Z = 2, CH_YAW = 3, CH_PITCH = 4} chan_t;

  // One row of the directed table. When typed is set, want is the prediction
  // read straight off the window; otherwise the predictor supplies it.
  typedef struct {
    bit                set_hor;
    logic [HOR_W-1:0]  hor;
    row_t              smp;
    bit                typed;
    row_t              want;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [HOR_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [SMP_W-1:0]  in_eye_x;
  logic signed [SMP_W-1:0]  in_eye_y;
  logic signed [SMP_W-1:0]  in_eye_z;
  logic signed [SMP_W-1:0]  in_yaw_angle;
  logic signed [SMP_W-1:0]  in_pitch_angle;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SMP_W-1:0]  out_pred_eye_x;
  logic signed [SMP_W-1:0]  out_pred_eye_y;
  logic signed [SMP_W-1:0]  out_pred_eye_z;
  logic signed [SMP_W-1:0]  out_pred_yaw;
  logic signed [SMP_W-1:0]  out_pred_pitch;

  // Predictor state: sample window, fill level, next slot and horizon
  row_t              win_hist [WIN];
  int                win_fill;
  int                win_slot;
  logic [HOR_W-1:0]  cur_horizon;

  row_t      pred_q [$];       // predictions waiting for the block's result items
  dir_row_t  dir_tab [$];
  int        n_err;
  int        cycles;
  int        feed_calm;

  // Random trajectory state
  int  traj_left;
  int  traj_kind;
  int  traj_k;
  int  traj_base  [NUM_CH];
  int  traj_slope [NUM_CH];

  string ch_label [NUM_CH] = '{"pred_eye_x", "pred_eye_y", "pred_eye_z", "pred_yaw",
                               "pred_pitch"};

  pose_linear_extrapolator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_eye_x       (in_eye_x),
    .in_eye_y       (in_eye_y),
    .in_eye_z       (in_eye_z),
    .in_yaw_angle   (in_yaw_angle),
    .in_pitch_angle (in_pitch_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pred_eye_x (out_pred_eye_x),
    .out_pred_eye_y (out_pred_eye_y),
    .out_pred_eye_z (out_pred_eye_z),
    .out_pred_yaw   (out_pred_yaw),
    .out_pred_pitch (out_pred_pitch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pack five channel values into one pose row, eye x in channel 0.
  function automatic row_t pose5(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
                                 input logic [SMP_W-1:0] z, input logic [SMP_W-1:0] yaw,
                                 input logic [SMP_W-1:0] pitch);
    row_t r;
    r[CH_X]     = x;
    r[CH_Y]     = y;
    r[CH_Z]     = z;
    r[CH_YAW]   = yaw;
    r[CH_PITCH] = pitch;
    return r;
  endfunction

  // Fit a line over the window, oldest sample at position 0, and evaluate it
  // horizon samples past the newest. Everything is exact in 64 bits; round
  // half away from zero, then clamp to 32 bits.
  function automatic logic [SMP_W-1:0] extrapolate(input int ch);
    longint total = 0;
    longint wsum  = 0;
    longint y, num, den, mag, q;
    for (int pos = 0; pos < WIN; pos++) begin
      y = longint'($signed(win_hist[(win_slot + pos) % WIN][ch]));
      total += y;
      wsum  += longint'(2 * pos - (WIN - 1)) * y;
    end
    num = longint'(WIN * WIN - 1) * total
        + 3 * (2 * longint'(cur_horizon) + WIN - 1) * wsum;
    den = longint'(WIN * (WIN * WIN - 1));
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[SMP_W-1:0];
  endfunction

  // Store one sample; once the window is full, report the prediction.
  function automatic void take_pose(input row_t s, output bit fired, output row_t pred);
    win_hist[win_slot] = s;
    win_slot = (win_slot + 1) % WIN;
    if (win_fill < WIN) win_fill++;
    fired = (win_fill == WIN);
    for (int ch = 0; ch < NUM_CH; ch++) pred[ch] = extrapolate(ch);
  endfunction

  // Idle cycles before the next item: mostly 0..19, with calm runs of zero.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Next random pose. Runs of 8..40 samples share one kind: a smooth ramp
  // with a little jitter, raw 32-bit noise, or full-scale corner values.
  function automatic row_t next_pose();
    row_t r;
    int   pick;
    if (traj_left == 0) begin
      traj_left = $urandom_range(8, 40);
      pick      = $urandom_range(0, 9);
      traj_kind = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
      traj_k    = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        traj_base[ch] = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        if ($urandom_range(0, 3) == 0)
          traj_slope[ch] = int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
        else
          traj_slope[ch] = int'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      end
    end
    traj_left--;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case (traj_kind)
        0: r[ch] = traj_base[ch] + traj_slope[ch] * traj_k
                 + int'($urandom_range(0, 255)) - 128;
        1: r[ch] = $urandom;
        default: begin
          case ($urandom_range(0, 6))
            0: r[ch] = SMP_MAX;
            1: r[ch] = SMP_MIN;
            2: r[ch] = '0;
            3: r[ch] = 32'd1;
            4: r[ch] = '1;
            5: r[ch] = SMP_MAX - 1;
            default: r[ch] = SMP_MIN + 1;
          endcase
        end
      endcase
    end
    traj_k++;
    return r;
  endfunction

  // Offer one sample and hold it until taken; then advance the predictor.
  task automatic send_pose(input row_t s, input bit typed, input row_t want);
    int   gap;
    bit   fired;
    row_t pred;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_eye_x       <= s[CH_X];
    in_eye_y       <= s[CH_Y];
    in_eye_z       <= s[CH_Z];
    in_yaw_angle   <= s[CH_YAW];
    in_pitch_angle <= s[CH_PITCH];
    do @(posedge clk); while (in_stall);
    take_pose(s, fired, pred);
    if (fired) pred_q.push_back(typed ? want : pred);
  endtask

  // Drain every pending prediction, let the block settle, then write horizon.
  task automatic set_horizon(input logic [HOR_W-1:0] h);
    in_valid <= 1'b0;
    while (pred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_horizon = h;
  endtask

  task automatic dir_add(input bit set_hor, input logic [HOR_W-1:0] hor, input row_t smp,
                         input bit typed, input row_t want);
    dir_row_t row;
    row.set_hor = set_hor;
    row.hor     = hor;
    row.smp     = smp;
    row.typed   = typed;
    row.want    = want;
    dir_tab.push_back(row);
  endtask

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("pose_linear_extrapolator_tb: done, errors");
      $finish;
    end
  end

  // Compare each accepted result item with the oldest waiting prediction.
  always @(posedge clk) begin
    row_t got;
    row_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = pose5(out_pred_eye_x, out_pred_eye_y, out_pred_eye_z, out_pred_yaw,
                  out_pred_pitch);
      if (pred_q.size() == 0) begin
        n_err++;
        $display("%0t: result item with nothing expected, got %h", $time, got);
      end else begin
        want = pred_q.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (got[ch] !== want[ch]) begin
            n_err++;
            $display("%0t: %s expected %h actual %h", $time, ch_label[ch], want[ch],
                     got[ch]);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off twice so that the block
  // fills and pushes back on the sender.
  initial begin : drain
    int wait_n;
    int calm;
    int taken;
    calm      = 0;
    taken     = 0;
    out_stall = 1'b1;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 100 || taken == 500) wait_n = LONG_HOLD;
      else wait_n = draw_wait(calm);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Sender: reset, directed table, random phases, drain and report.
  initial begin : feed
    row_t zero_r, max_r, min_r, flat_r;
    logic [HOR_W-1:0] phase_hor [6];
    n_err          = 0;
    feed_calm      = 0;
    traj_left      = 0;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_eye_x       = '0;
    in_eye_y       = '0;
    in_eye_z       = '0;
    in_yaw_angle   = '0;
    in_pitch_angle = '0;
    for (int i = 0; i < WIN; i++) win_hist[i] = '0;
    win_fill    = 0;
    win_slot    = 0;
    cur_horizon = HOR_RST;

    zero_r = '0;
    max_r  = pose5(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    min_r  = pose5(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    flat_r = pose5(32'h0001_0000, -32'sh0001_0000, SMP_MAX, SMP_MIN, 32'd12345);

    // Window filling: no result until the third item, then all zeros.
    dir_add(0, '0, zero_r, 0, zero_r);
    dir_add(0, '0, zero_r, 0, zero_r);
    dir_add(0, '0, zero_r, 1, zero_r);
    // Steep climb to full scale saturates high; a full-scale constant window
    // predicts itself.
    dir_add(0, '0, max_r, 1, max_r);
    dir_add(0, '0, max_r, 1, max_r);
    dir_add(0, '0, max_r, 1, max_r);
    // Plunge to negative full scale saturates low.
    dir_add(0, '0, min_r, 1, min_r);
    dir_add(0, '0, min_r, 1, min_r);
    dir_add(0, '0, min_r, 1, min_r);
    // Alternating bit patterns and mixed signs
    dir_add(0, '0, pose5(32'd1, '1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000), 0, zero_r);
    dir_add(0, '0, pose5(32'h7FFF_0000, 32'h8001_0000, -32'sd2, 32'd2, 32'h0000_FFFF), 0,
            zero_r);
    // Horizon zero: a lone step of +-6 or +-18 divides exactly, with no rounding.
    dir_add(1, '0, zero_r, 0, zero_r);
    dir_add(0, '0, zero_r, 0, zero_r);
    dir_add(0, '0, pose5(32'd6, -32'sd6, 32'd18, -32'sd18, 32'd1), 0, zero_r);
    // Largest horizon: a flat window still predicts itself.
    dir_add(1, '1, flat_r, 0, zero_r);
    dir_add(0, '0, flat_r, 0, zero_r);
    dir_add(0, '0, flat_r, 1, flat_r);
    dir_add(0, '0, pose5(32'h0003_0000, -32'sh0003_0000, SMP_MAX - 5, SMP_MIN + 5, 32'd0),
            0, zero_r);
    dir_add(0, '0, pose5(32'h0005_0000, -32'sh0004_0000, SMP_MAX, SMP_MIN, '1), 0, zero_r);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_hor) set_horizon(dir_tab[i].hor);
      send_pose(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, the extremes of horizon among them
    phase_hor[0] = '0;
    phase_hor[1] = '1;
    phase_hor[2] = HOR_W'($urandom_range(0, 63));
    phase_hor[3] = HOR_W'(1);
    phase_hor[4] = HOR_W'($urandom_range(0, 63));
    phase_hor[5] = HOR_RST;
    foreach (phase_hor[p]) begin
      set_horizon(phase_hor[p]);
      repeat (PHASE_LEN) send_pose(next_pose(), 0, zero_r);
    end

    in_valid <= 1'b0;
    while (pred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0) begin
      $display("pose_linear_extrapolator_tb: done, clean");
    end else begin
      $display("pose_linear_extrapolator_tb: done, errors");
    end
    $finish;
  end

endmodule
